[src/rpdf_pkg.sv]
package rpdf_pkg;

    localparam int DEPTH   = 24;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NODE_W  = 24;
    localparam int PKT_W   = 32;
    localparam int BATCH_W = 16;
    localparam int KEY_W   = NODE_W + PKT_W + BATCH_W;
    localparam int S_DATA_W = ((KEY_W + 7) / 8) * 8;
    localparam int M_DATA_W = 8;

    typedef logic [KEY_W-1:0] key_t;

    // bytes past the first zero byte of the id read as zero
    function automatic logic [NODE_W-1:0] canon_node(input logic [NODE_W-1:0] raw);
        logic [NODE_W-1:0] res;
        begin
            res = raw;
            if (raw[7:0] == 8'd0)
            begin
                res = '0;
            end
            else if (raw[15:8] == 8'd0)
            begin
                res = {16'd0, raw[7:0]};
            end
            return res;
        end
    endfunction

endpackage

[src/recent_packet_duplicate_filter_core.sv]
// recent packet duplicate filter
// input channel s_*: one packet identity per request, tdata holds node_ident
// in bits 23:0, packet_number in 55:24 and batch_number in 71:56.
// output channel m_*: one result per request, tdata bit 0 is is_repeat,
// set when the identity matches a valid entry of the recent window.
// a miss stores the identity in the slot under a round-robin pointer that
// wraps after the last slot, overwriting the oldest entry once full.
// the window is held in a single-port-read memory walked by one shared
// comparator, one entry per cycle with a registered read.
// a request is accepted into key_reg, the window is walked entry by entry
// (ending early on a hit), and the result is posted to the output register.
// s_tready is high only while idle, so throughput is one request per
// walk, longer while the output stalls; the walk length sets the rate.
// the result sits in an output register; while m_tready is low the result
// holds and the next request is accepted, but its result waits until the
// output register is taken.
// reset (rst_n low, asynchronous) clears all valid marks and the pointer;
// entry contents need no clearing.
module recent_packet_duplicate_filter_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // node_ident, packet_number, batch_number
    input  logic [rpdf_pkg::S_DATA_W-1:0] s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // is_repeat, zero fill
    output logic [rpdf_pkg::M_DATA_W-1:0] m_tdata
);
    import rpdf_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t                  state_reg;
    key_t                    key_reg;
    logic [IDX_W-1:0]        idx_reg;
    logic [IDX_W-1:0]        slot_reg;
    logic                    cmp_live_reg;
    logic                    rd_last_reg;
    logic                    rd_valid_reg;
    logic                    hit_reg;
    logic [DEPTH-1:0]        valid_reg;
    logic                    m_tvalid_reg;
    logic                    is_repeat_reg;

    key_t                    mem [DEPTH];
    key_t                    rd_data_reg;

    logic                    match;
    logic                    scan_end;
    logic                    out_free;
    logic                    mem_re;
    logic                    mem_we;
    key_t                    in_key;

    assign in_key   = {s_tdata[KEY_W-1:NODE_W], canon_node(s_tdata[NODE_W-1:0])};
    assign match    = rd_valid_reg && (rd_data_reg == key_reg);
    assign scan_end = cmp_live_reg && (match || rd_last_reg);
    assign out_free = !m_tvalid_reg || m_tready;
    assign mem_re   = (state_reg == ST_SCAN) && !scan_end;
    assign mem_we   = (state_reg == ST_DONE) && out_free && !hit_reg;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_DATA_W-1){1'b0}}, is_repeat_reg};

    // window memory, one read and one write port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[slot_reg] <= key_reg;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            slot_reg      <= '0;
            cmp_live_reg  <= 1'b0;
            rd_last_reg   <= 1'b0;
            rd_valid_reg  <= 1'b0;
            hit_reg       <= 1'b0;
            valid_reg     <= '0;
            m_tvalid_reg  <= 1'b0;
            is_repeat_reg <= 1'b0;
            key_reg       <= '0;
        end
        else
        begin
            // in ST_DONE a taken result is replaced by the new one below
            if (m_tvalid_reg && m_tready && (state_reg != ST_DONE))
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        key_reg      <= in_key;
                        idx_reg      <= '0;
                        cmp_live_reg <= 1'b0;
                        state_reg    <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (scan_end)
                    begin
                        hit_reg      <= match;
                        cmp_live_reg <= 1'b0;
                        state_reg    <= ST_DONE;
                    end
                    else
                    begin
                        rd_valid_reg <= valid_reg[idx_reg];
                        rd_last_reg  <= (idx_reg == IDX_W'(DEPTH - 1));
                        cmp_live_reg <= 1'b1;
                        if (idx_reg != IDX_W'(DEPTH - 1))
                        begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg  <= 1'b1;
                        is_repeat_reg <= hit_reg;
                        state_reg     <= ST_IDLE;
                        if (!hit_reg)
                        begin
                            valid_reg[slot_reg] <= 1'b1;
                            if (slot_reg == IDX_W'(DEPTH - 1))
                            begin
                                slot_reg <= '0;
                            end
                            else
                            begin
                                slot_reg <= slot_reg + 1'b1;
                            end
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

[verif/recent_packet_duplicate_filter_core_test.sv]
`timescale 1ns / 1ps

module recent_packet_duplicate_filter_core_test;

    import rpdf_pkg::*;

    localparam int STALL_LIMIT     = 3000;
    localparam int DRAIN_CYCLES    = 40;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int HISTORY_LEN     = 48;

    // node in the low bits, so the struct packs straight into tdata
    typedef struct packed
    {
        logic [BATCH_W-1:0] batch;
        logic [PKT_W-1:0]   pkt;
        logic [NODE_W-1:0]  node;
    } packet_id_t;

    class dup_window_scoreboard;
        bit          slot_used [DEPTH];
        packet_id_t  slot_id [DEPTH];
        int unsigned write_slot;
        bit          expected_repeat [$];
        int unsigned errors;

        function new();
            for (int i = 0; i < DEPTH; i++)
            begin
                slot_used[i] = 1'b0;
            end
            write_slot = 0;
            errors = 0;
        endfunction

        // id is a terminated string: bytes past the first zero byte do not count
        function logic [NODE_W-1:0] trim_node(logic [NODE_W-1:0] raw);
            logic [NODE_W-1:0] t;
            t = raw;
            if (raw[7:0] == 8'd0)
            begin
                t = '0;
            end
            else if (raw[15:8] == 8'd0)
            begin
                t[NODE_W-1:8] = '0;
            end
            return t;
        endfunction

        function void note_packet(packet_id_t raw);
            packet_id_t id;
            bit         hit;
            id = raw;
            id.node = trim_node(raw.node);
            hit = 1'b0;
            for (int i = 0; i < DEPTH; i++)
            begin
                if (slot_used[i] && slot_id[i] == id)
                begin
                    hit = 1'b1;
                end
            end
            if (!hit)
            begin
                slot_id[write_slot] = id;
                slot_used[write_slot] = 1'b1;
                write_slot = (write_slot == DEPTH - 1) ? 0 : write_slot + 1;
            end
            expected_repeat.push_back(hit);
        endfunction

        function void check_verdict(bit got);
            bit want;
            if (expected_repeat.size() == 0)
            begin
                $error("is_repeat: result with no request pending, expected none, actual %0d",
                       got);
                errors++;
            end
            else
            begin
                want = expected_repeat.pop_front();
                if (want != got)
                begin
                    $error("is_repeat mismatch: expected %0d, actual %0d", want, got);
                    errors++;
                end
            end
        endfunction

        function void close_out();
            if (expected_repeat.size() != 0)
            begin
                $error("is_repeat: expected %0d more results, actual 0",
                       expected_repeat.size());
                errors += expected_repeat.size();
            end
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_left = 0;
    int idle_cycles = 0;

    packet_id_t           history [$];
    dup_window_scoreboard sb;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    recent_packet_duplicate_filter_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // receiver, with a long hold-off when asked
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                sb.note_packet(packet_id_t'(s_tdata));
            end
            if (m_tvalid && m_tready)
            begin
                sb.check_verdict(m_tdata[0]);
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles = idle_cycles + 1;
            end
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("FAIL recent_packet_duplicate_filter_core");
                $finish;
            end
        end
    end

    function packet_id_t make_id(logic [NODE_W-1:0] node, logic [PKT_W-1:0] pkt,
                                 logic [BATCH_W-1:0] batch);
        packet_id_t id;
        id.node = node;
        id.pkt = pkt;
        id.batch = batch;
        return id;
    endfunction

    // fill the bytes past the terminator with junk
    function logic [NODE_W-1:0] scramble_tail(logic [NODE_W-1:0] node);
        logic [NODE_W-1:0] t;
        t = node;
        if (node[7:0] == 8'd0)
        begin
            t[NODE_W-1:8] = 16'($urandom());
        end
        else if (node[15:8] == 8'd0)
        begin
            t[NODE_W-1:16] = 8'($urandom());
        end
        return t;
    endfunction

    function packet_id_t fresh_packet();
        packet_id_t id;
        id.node = NODE_W'($urandom());
        case ($urandom_range(9))
            0: id.node[7:0] = 8'd0;
            1: id.node[15:8] = 8'd0;
            2: id.node = NODE_W'($urandom_range(3));
            default: ;
        endcase
        id.pkt = $urandom_range(1) ? PKT_W'($urandom()) : PKT_W'($urandom_range(3));
        id.batch = $urandom_range(1) ? BATCH_W'($urandom()) : BATCH_W'($urandom_range(3));
        return id;
    endfunction

    // mostly fresh identities, some recent ones, a few already out of the window
    function packet_id_t next_packet();
        packet_id_t id;
        if (history.size() > 0 && $urandom_range(99) < 45)
        begin
            id = history[$urandom_range(history.size() - 1)];
            if ($urandom_range(3) == 0)
            begin
                id.node = scramble_tail(id.node);
            end
        end
        else
        begin
            id = fresh_packet();
        end
        return id;
    endfunction

    task send_packet(input packet_id_t id);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= S_DATA_W'(id);
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        history.push_back(id);
        if (history.size() > HISTORY_LEN)
        begin
            void'(history.pop_front());
        end
    endtask

    task run_phase(input int count, input int idle, input int stall);
        send_idle_pct = idle;
        stall_pct = stall;
        repeat (count)
        begin
            send_packet(next_packet());
        end
    endtask

    initial
    begin
        sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes, terminator aliasing, single field differences
        send_packet(make_id('0, '0, '0));
        send_packet(make_id('0, '0, '0));
        send_packet(make_id(24'h123400, '0, '0));
        send_packet(make_id('1, '1, '1));
        send_packet(make_id(24'h000041, 32'd5, 16'd7));
        send_packet(make_id(24'h7F0041, 32'd5, 16'd7));
        send_packet(make_id(24'h414243, 32'd5, 16'd7));
        send_packet(make_id(24'h434241, 32'd5, 16'd7));
        send_packet(make_id(24'h414243, 32'd6, 16'd7));
        send_packet(make_id(24'h414243, 32'h8000_0005, 16'h8007));
        // fill the window to one slot short of its end, so the oldest entries are still held
        for (int i = 0; i < 16; i++)
        begin
            send_packet(make_id(24'h303030 + NODE_W'(i), PKT_W'(i), BATCH_W'(i)));
        end
        send_packet(make_id('0, '0, '0));
        send_packet(make_id('1, '1, '1));

        run_phase(260, 0, 0);
        run_phase(260, 61, 0);
        run_phase(260, 0, 61);
        run_phase(260, 37, 37);

        // receiver holds off while requests keep coming
        send_idle_pct = 0;
        stall_pct = 0;
        hold_left = HOLD_OFF_CYCLES;
        repeat (60)
        begin
            send_packet(next_packet());
        end
        s_tvalid <= 1'b0;

        while (sb.expected_repeat.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        sb.close_out();
        if (sb.errors == 0)
        begin
            $display("PASS recent_packet_duplicate_filter_core");
        end
        else
        begin
            $display("FAIL recent_packet_duplicate_filter_core");
        end
        $finish;
    end

endmodule

[files.f]
src/rpdf_pkg.sv
src/recent_packet_duplicate_filter_core.sv
verif/recent_packet_duplicate_filter_core_test.sv
